// ===== hw/rtl/ppsm_pkg.sv =====
// ============================================================================
// Pulse period speed meter package
// Shared widths, register indexes, event codes and the sequencer microcode.
// ============================================================================
`default_nettype none

package ppsm_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned WINDOW_LEN_DEF = 8;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CONST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'd1;

  localparam logic [DATA_W-1:0] SPEED_CONST_RST = 32'd0;
  localparam logic [DATA_W-1:0] TIMEOUT_RST     = 32'd1000000;

  // Event kinds
  localparam logic REQ_PULSE  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Sequencer step addresses
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_SUM0  = 4'd1;
  localparam logic [STEP_W-1:0] S_RD    = 4'd2;
  localparam logic [STEP_W-1:0] S_ACC   = 4'd3;
  localparam logic [STEP_W-1:0] S_DIV1  = 4'd4;
  localparam logic [STEP_W-1:0] S_WAIT1 = 4'd5;
  localparam logic [STEP_W-1:0] S_CHK   = 4'd6;
  localparam logic [STEP_W-1:0] S_DIV2  = 4'd7;
  localparam logic [STEP_W-1:0] S_WAIT2 = 4'd8;
  localparam logic [STEP_W-1:0] S_OK    = 4'd9;
  localparam logic [STEP_W-1:0] S_BAD   = 4'd10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_EVENT,      // accept an event, update pulse state and window
    OP_SUM_INIT,   // clear sum and read index
    OP_RD,         // read window entry, bump index
    OP_ACC,        // add read data into sum
    OP_DIV_MEAN,   // start sum / fill
    OP_DIV_SPEED,  // start speed_constant / mean
    OP_OUT_OK,     // load result with quotient
    OP_OUT_BAD     // load result marked invalid
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_FILL_ZERO,
    C_IDX_NE_N,
    C_DIV_BUSY,
    C_QUOT_ZERO,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;   // fall through to S_IDLE instead of step + 1
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE, last: 1'b0};
    case (step)
      S_IDLE:  w = '{op: OP_EVENT,     cond: C_NO_INPUT,  target: S_IDLE,  last: 1'b0};
      S_SUM0:  w = '{op: OP_SUM_INIT,  cond: C_FILL_ZERO, target: S_BAD,   last: 1'b0};
      S_RD:    w = '{op: OP_RD,        cond: C_NEXT,      target: S_IDLE,  last: 1'b0};
      S_ACC:   w = '{op: OP_ACC,       cond: C_IDX_NE_N,  target: S_RD,    last: 1'b0};
      S_DIV1:  w = '{op: OP_DIV_MEAN,  cond: C_NEXT,      target: S_IDLE,  last: 1'b0};
      S_WAIT1: w = '{op: OP_NONE,      cond: C_DIV_BUSY,  target: S_WAIT1, last: 1'b0};
      S_CHK:   w = '{op: OP_NONE,      cond: C_QUOT_ZERO, target: S_BAD,   last: 1'b0};
      S_DIV2:  w = '{op: OP_DIV_SPEED, cond: C_NEXT,      target: S_IDLE,  last: 1'b0};
      S_WAIT2: w = '{op: OP_NONE,      cond: C_DIV_BUSY,  target: S_WAIT2, last: 1'b0};
      S_OK:    w = '{op: OP_OUT_OK,    cond: C_OUT_BUSY,  target: S_OK,    last: 1'b1};
      S_BAD:   w = '{op: OP_OUT_BAD,   cond: C_OUT_BUSY,  target: S_BAD,   last: 1'b1};
      default: w = '{op: OP_NONE,      cond: C_ALWAYS,    target: S_IDLE,  last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppsm_in_if.sv =====
// ============================================================================
// Event channel
// Valid/ready channel carrying one timestamped event per transaction.
// ============================================================================
`default_nettype none

interface ppsm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ppsm_pkg::DATA_W-1:0] time_us;

  modport source (output valid, output req_type, output time_us, input ready);
  modport sink   (input valid, input req_type, input time_us, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ppsm_out_if.sv =====
// ============================================================================
// Result channel
// Valid/ready channel carrying one speed result per transaction.
// ============================================================================
`default_nettype none

interface ppsm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        speed_valid;
  logic [ppsm_pkg::DATA_W-1:0] speed_mph100;
  logic [ppsm_pkg::DATA_W-1:0] pulse_count;

  modport source (output valid, output speed_valid, output speed_mph100,
                  output pulse_count, input ready);
  modport sink   (input valid, input speed_valid, input speed_mph100,
                  input pulse_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ppsm_div.sv =====
// ============================================================================
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module ppsm_div #(
  parameter int unsigned DIVIDEND_W = 35,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dsr_q, rem_d;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};
  assign rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_period_speed_meter.sv =====
// ============================================================================
// Pulse period speed meter
// Moving-average wheel speed from timestamped pulse and update events.
// ============================================================================
//
//  channel  dir  transaction                          payload
//  -------  ---  -----------------------------------  --------------------------
//  evt_i    in   one event (pulse or update)          req_type, time_us
//  res_o    out  one result per event                 speed_valid, speed_mph100,
//                                                     pulse_count
//  cfg      in   register write, cfg_we_i high        cfg_idx_i, cfg_data_i
//
//  An event runs the window sum, which reads the ring memory one entry at a
//  time (a read step, then an accumulate step), and both divisions go through
//  one shared serial divider, one bit per cycle. The sum is shorter while the
//  window is not full; both divisions are skipped when it is empty, and the
//  second one when the mean is zero.
//  Reset clears all control and window state; the ring itself needs no clear
//  since only the first fill entries are ever summed.
//  A stalled result sits in the output register; the next event is accepted
//  meanwhile, and the sequencer only waits when it has a second result ready.
// ============================================================================
`default_nettype none

module pulse_period_speed_meter #(
  parameter int unsigned WINDOW_LEN = ppsm_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ppsm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ppsm_pkg::DATA_W-1:0]    cfg_data_i,
  ppsm_in_if.sink                             evt_i,
  ppsm_out_if.source                          res_o
);

  localparam int unsigned DW     = ppsm_pkg::DATA_W;
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W  = DW + $clog2(WINDOW_LEN);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] speed_const_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_const_q <= ppsm_pkg::SPEED_CONST_RST;
      timeout_q     <= ppsm_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppsm_pkg::CFG_SPEED_CONST: speed_const_q <= cfg_data_i;
        ppsm_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: step counter + microcode ROM
  // --------------------------------------------------------------------------
  logic [ppsm_pkg::STEP_W-1:0] step_q, step_d;
  ppsm_pkg::ucode_t            uc;
  logic                        jump;

  logic                 div_busy;
  logic [SUM_W-1:0]     div_quot;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [FILL_W-1:0]    idx_q;
  logic                 res_valid_q;
  logic                 out_busy;

  assign uc       = ppsm_pkg::ucode_rom(step_q);
  assign out_busy = res_valid_q && !res_o.ready;

  always_comb begin
    case (uc.cond)
      ppsm_pkg::C_NEXT:      jump = 1'b0;
      ppsm_pkg::C_ALWAYS:    jump = 1'b1;
      ppsm_pkg::C_NO_INPUT:  jump = !evt_i.valid;
      ppsm_pkg::C_FILL_ZERO: jump = (fill_q == '0);
      ppsm_pkg::C_IDX_NE_N:  jump = (idx_q != fill_q);
      ppsm_pkg::C_DIV_BUSY:  jump = div_busy;
      ppsm_pkg::C_QUOT_ZERO: jump = (div_quot[DW-1:0] == '0);
      ppsm_pkg::C_OUT_BUSY:  jump = out_busy;
      default:               jump = 1'b1;
    endcase
    if (jump) begin
      step_d = uc.target;
    end else if (uc.last) begin
      step_d = ppsm_pkg::S_IDLE;
    end else begin
      step_d = step_q + ppsm_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ppsm_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // --------------------------------------------------------------------------
  // Event handling: pulse timing and window bookkeeping
  // --------------------------------------------------------------------------
  logic              evt_acc;
  logic [DW-1:0]     prev_q, prev_d;
  logic [DW-1:0]     pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  logic [DW-1:0]     count_q, count_d;
  logic [IDX_W-1:0]  wpos_q, wpos_d, wpos_base;
  logic [FILL_W-1:0] fill_base;
  logic [DW-1:0]     elapsed;
  logic              push;

  assign evt_i.ready = (uc.op == ppsm_pkg::OP_EVENT);
  assign evt_acc     = evt_i.valid && evt_i.ready;
  assign elapsed     = evt_i.time_us - prev_q;

  always_comb begin
    prev_d     = prev_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    count_d    = count_q;
    fill_base  = fill_q;
    wpos_base  = wpos_q;
    fill_d     = fill_q;
    wpos_d     = wpos_q;
    push       = 1'b0;
    if (evt_acc) begin
      if (evt_i.req_type == ppsm_pkg::REQ_PULSE) begin
        // first pulse (or one after timeout) only latches the time
        if (prev_q != '0) begin
          pend_d     = elapsed;
          pend_vld_d = 1'b1;
          count_d    = count_q + DW'(1);
        end
        prev_d = evt_i.time_us;
      end else begin
        // timeout empties the window before the pending interval goes in
        if (prev_q != '0 && elapsed > timeout_q) begin
          fill_base = '0;
          wpos_base = '0;
          prev_d    = '0;
        end
        fill_d = fill_base;
        wpos_d = wpos_base;
        if (pend_vld_q) begin
          push       = 1'b1;
          pend_vld_d = 1'b0;
          if (fill_base < FILL_W'(WINDOW_LEN)) begin
            fill_d = fill_base + FILL_W'(1);
          end
          if (wpos_base == IDX_W'(WINDOW_LEN - 1)) begin
            wpos_d = '0;
          end else begin
            wpos_d = wpos_base + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      count_q    <= '0;
      fill_q     <= '0;
      wpos_q     <= '0;
    end else begin
      prev_q     <= prev_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      count_q    <= count_d;
      fill_q     <= fill_d;
      wpos_q     <= wpos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Interval ring: one write port (event push), one registered read port (sum)
  // --------------------------------------------------------------------------
  logic [DW-1:0] ring_mem [WINDOW_LEN];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ring_mem[wpos_base] <= pend_q;
    end
    if (uc.op == ppsm_pkg::OP_RD) begin
      rd_data_q <= ring_mem[idx_q[IDX_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Window sum over the first fill entries
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (uc.op == ppsm_pkg::OP_SUM_INIT) begin
      idx_q <= '0;
    end else if (uc.op == ppsm_pkg::OP_RD) begin
      idx_q <= idx_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.op == ppsm_pkg::OP_SUM_INIT) begin
      sum_q <= '0;
    end else if (uc.op == ppsm_pkg::OP_ACC) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider: mean = sum / fill, then speed = speed_constant / mean
  // --------------------------------------------------------------------------
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [DW-1:0]    div_divisor;

  assign div_start = (uc.op == ppsm_pkg::OP_DIV_MEAN) ||
                     (uc.op == ppsm_pkg::OP_DIV_SPEED);

  always_comb begin
    if (uc.op == ppsm_pkg::OP_DIV_MEAN) begin
      div_dividend = sum_q;
      div_divisor  = DW'(fill_q);
    end else begin
      // quotient still holds the mean from the first division
      div_dividend = SUM_W'(speed_const_q);
      div_divisor  = div_quot[DW-1:0];
    end
  end

  ppsm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic          out_load;
  logic          out_ok;
  logic          res_spd_vld_q;
  logic [DW-1:0] res_speed_q, res_count_q;

  assign out_ok   = (uc.op == ppsm_pkg::OP_OUT_OK);
  assign out_load = (out_ok || uc.op == ppsm_pkg::OP_OUT_BAD) && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_spd_vld_q <= out_ok;
      res_speed_q   <= out_ok ? div_quot[DW-1:0] : '0;
      res_count_q   <= count_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.speed_valid  = res_spd_vld_q;
  assign res_o.speed_mph100 = res_speed_q;
  assign res_o.pulse_count  = res_count_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Pulse period speed meter testbench
// Sends pulse and update events through the event channel and checks every
// result transaction against a cycle-free model of the speed window, across
// several calibration and timeout settings.
// ============================================================================

module testbench;

  localparam int unsigned DATA_W         = ppsm_pkg::DATA_W;
  localparam int unsigned CFG_IDX_W      = ppsm_pkg::CFG_IDX_W;
  localparam int unsigned WIN            = ppsm_pkg::WINDOW_LEN_DEF;
  localparam int unsigned HOLD_AT_RESULT = 160;  // result count that starts the long stall
  localparam int unsigned HOLD_CYCLES    = 600;  // long enough to back up the event side

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] time_us;
  } meter_event_t;

  typedef struct packed {
    logic              speed_valid;
    logic [DATA_W-1:0] speed_mph100;
    logic [DATA_W-1:0] pulse_count;
  } speed_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  ppsm_in_if  evt_if ();
  ppsm_out_if res_if ();

  pulse_period_speed_meter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Speed model: own copy of registers and window state
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] speed_const_reg = ppsm_pkg::SPEED_CONST_RST;
  logic [DATA_W-1:0] timeout_reg     = ppsm_pkg::TIMEOUT_RST;

  logic [DATA_W-1:0] last_pulse_us  = '0;  // 0 = no pulse seen yet
  logic [DATA_W-1:0] held_interval  = '0;  // measured, not yet in the window
  logic              held_valid     = 1'b0;
  logic [DATA_W-1:0] intervals_seen = '0;
  logic [DATA_W-1:0] window_ring [WIN];
  int unsigned       win_fill       = 0;
  int unsigned       win_pos        = 0;
  logic              win_full       = 1'b0;

  speed_result_t speed_expected [$];
  meter_event_t  events_to_send [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  bit          quiet_mode   = 1'b0;  // no idling on either side

  initial begin
    for (int k = 0; k < WIN; k++) window_ring[k] = '0;
  end

  task automatic clear_window();
    for (int k = 0; k < WIN; k++) window_ring[k] = '0;
    win_fill = 0;
    win_pos  = 0;
    win_full = 1'b0;
  endtask

  // Apply one accepted event to the model and queue the result it causes.
  task automatic meter_predict(input logic kind, input logic [DATA_W-1:0] now_us);
    logic [DATA_W-1:0] since;
    logic [DATA_W+7:0] total;
    logic [DATA_W+7:0] quot;
    logic [DATA_W-1:0] mean;
    int unsigned       n;
    speed_result_t     r;
    if (kind == ppsm_pkg::REQ_PULSE) begin
      if (last_pulse_us == '0) begin
        // first pulse (or one latched at time zero): only the time is kept
        last_pulse_us = now_us;
      end else begin
        // a newer interval overwrites one still waiting for an update
        held_interval  = now_us - last_pulse_us;
        last_pulse_us  = now_us;
        held_valid     = 1'b1;
        intervals_seen = intervals_seen + 1;
      end
    end else begin
      since = now_us - last_pulse_us;
      if (last_pulse_us != '0 && since > timeout_reg) begin
        clear_window();
        last_pulse_us = '0;
      end
      // pending interval still goes in after a timeout clear
      if (held_valid) begin
        window_ring[win_pos] = held_interval;
        if (!win_full) begin
          if (win_fill < WIN) win_fill++;
          if (win_fill == WIN) win_full = 1'b1;
        end
        win_pos    = (win_pos + 1) % WIN;
        held_valid = 1'b0;
      end
    end

    n = win_full ? WIN : win_fill;
    r = '0;
    if (n != 0) begin
      total = '0;
      for (int k = 0; k < n; k++) total += window_ring[k];
      quot = total / n;
      mean = quot[DATA_W-1:0];
      if (mean != '0) begin
        r.speed_valid  = 1'b1;
        r.speed_mph100 = speed_const_reg / mean;
      end
    end
    r.pulse_count = intervals_seen;
    speed_expected.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH: %s", what);
  endtask

  function automatic int unsigned pick_idle();
    return quiet_mode ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic queue_event(input logic kind, input logic [DATA_W-1:0] t);
    meter_event_t ev;
    ev.req_type = kind;
    ev.time_us  = t;
    events_to_send.push_back(ev);
  endtask

  // Registers are only touched with nothing in flight; model follows at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == ppsm_pkg::CFG_SPEED_CONST) speed_const_reg = data;
    else if (idx == ppsm_pkg::CFG_TIMEOUT) timeout_reg = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (events_to_send.size() != 0 || evt_if.valid || speed_expected.size() != 0)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Event driver: pops pending events, idles a drawn number of cycles per
  // transaction. Half the gaps only count while the block is ready, so they
  // land in its idle phase rather than under the computation; during the
  // long receiver hold-off every gap counts, so events keep being offered.
  // --------------------------------------------------------------------------
  int unsigned gap_left     = 0;
  bit          gap_on_ready = 1'b0;
  int unsigned hold_left    = 0;

  always @(posedge clk_i) begin
    meter_event_t nxt;
    int unsigned  gap;
    if (!rst_ni) begin
      evt_if.valid <= 1'b0;
      gap_left     <= 0;
      gap_on_ready <= 1'b0;
    end else if (evt_if.valid && evt_if.ready) begin
      meter_predict(evt_if.req_type, evt_if.time_us);
      gap = pick_idle();
      if (gap == 0 && events_to_send.size() != 0) begin
        // back to back: valid stays high, payload moves on
        nxt = events_to_send.pop_front();
        evt_if.req_type <= nxt.req_type;
        evt_if.time_us  <= nxt.time_us;
      end else begin
        evt_if.valid <= 1'b0;
        gap_left     <= gap;
        gap_on_ready <= 1'($urandom_range(0, 1));
      end
    end else if (!evt_if.valid) begin
      if (gap_left != 0) begin
        if (!gap_on_ready || evt_if.ready || hold_left != 0) gap_left <= gap_left - 1;
      end else if (events_to_send.size() != 0) begin
        nxt = events_to_send.pop_front();
        evt_if.valid    <= 1'b1;
        evt_if.req_type <= nxt.req_type;
        evt_if.time_us  <= nxt.time_us;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each transaction against the oldest expectation.
  // Ready stall is counted only while a result is offered, so it always bites.
  // --------------------------------------------------------------------------
  int unsigned res_wait   = 0;
  bit          start_hold = 1'b0;

  always @(posedge clk_i) begin
    speed_result_t want;
    speed_result_t got;
    int unsigned   w;
    bit            hold_now;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_wait     <= 0;
      start_hold   <= 1'b0;
    end else if (res_if.valid && res_if.ready) begin
      results_seen++;
      got.speed_valid  = res_if.speed_valid;
      got.speed_mph100 = res_if.speed_mph100;
      got.pulse_count  = res_if.pulse_count;
      if (speed_expected.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected: %p", results_seen, got));
      end else begin
        want = speed_expected.pop_front();
        if (got.speed_valid !== want.speed_valid)
          flag_mismatch($sformatf("result %0d speed_valid got %0b want %0b",
                                  results_seen, got.speed_valid, want.speed_valid));
        if (got.speed_mph100 !== want.speed_mph100)
          flag_mismatch($sformatf("result %0d speed_mph100 got %0h want %0h",
                                  results_seen, got.speed_mph100, want.speed_mph100));
        if (got.pulse_count !== want.pulse_count)
          flag_mismatch($sformatf("result %0d pulse_count got %0h want %0h",
                                  results_seen, got.pulse_count, want.pulse_count));
      end
      w        = pick_idle();
      hold_now = (results_seen == HOLD_AT_RESULT);
      res_if.ready <= (w == 0) && !hold_now;
      res_wait     <= w;
      start_hold   <= hold_now;
    end else begin
      start_hold <= 1'b0;
      if (!res_if.ready && res_if.valid && !start_hold && hold_left == 0) begin
        if (res_wait != 0) res_wait <= res_wait - 1;
        else res_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here; the driver keeps offering meanwhile.
  always @(posedge clk_i) begin
    if (!rst_ni) hold_left <= 0;
    else if (start_hold) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] clock_now;
    logic [DATA_W-1:0] step;
    int unsigned       roll;
    int unsigned       n_items;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    evt_if.valid    = 1'b0;
    evt_if.req_type = ppsm_pkg::REQ_PULSE;
    evt_if.time_us  = '0;
    res_if.ready    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: constant 0, timeout 1000000.
    queue_event(ppsm_pkg::REQ_UPDATE, 32'd5);             // empty window -> invalid
    queue_event(ppsm_pkg::REQ_PULSE,  32'd0);             // pulse at time zero stays "first"
    queue_event(ppsm_pkg::REQ_PULSE,  32'hFFFF_FFFF);     // first real pulse, latch only
    queue_event(ppsm_pkg::REQ_PULSE,  32'h0000_001F);     // interval across the wrap
    queue_event(ppsm_pkg::REQ_PULSE,  32'h0000_001F);     // zero interval replaces pending
    queue_event(ppsm_pkg::REQ_UPDATE, 32'h0000_0020);     // window {0}: zero mean -> invalid
    queue_event(ppsm_pkg::REQ_PULSE,  32'h0000_041F);
    queue_event(ppsm_pkg::REQ_UPDATE, 32'h41F + 32'd1000000);  // exactly at timeout: kept
    queue_event(ppsm_pkg::REQ_UPDATE, 32'h41F + 32'd1000001);  // one past: window cleared
    wait_drained();

    // Both registers at their maximum.
    write_reg(ppsm_pkg::CFG_SPEED_CONST, 32'hFFFF_FFFF);
    write_reg(ppsm_pkg::CFG_TIMEOUT,     32'hFFFF_FFFF);
    queue_event(ppsm_pkg::REQ_PULSE,  32'd1000);
    queue_event(ppsm_pkg::REQ_PULSE,  32'd1001);          // interval 1
    queue_event(ppsm_pkg::REQ_UPDATE, 32'd1001);          // mean 1 -> full-scale speed
    queue_event(ppsm_pkg::REQ_PULSE,  32'd1000);          // interval 0xFFFFFFFF
    queue_event(ppsm_pkg::REQ_UPDATE, 32'd2000);          // 33-bit sum in the mean
    queue_event(ppsm_pkg::REQ_UPDATE, 32'd0);             // nothing pending
    wait_drained();

    // Both registers at zero: any elapsed time is a timeout.
    write_reg(ppsm_pkg::CFG_SPEED_CONST, 32'd0);
    write_reg(ppsm_pkg::CFG_TIMEOUT,     32'd0);
    queue_event(ppsm_pkg::REQ_PULSE,  32'd5000);
    queue_event(ppsm_pkg::REQ_UPDATE, 32'd5000);          // zero elapsed: no clear
    queue_event(ppsm_pkg::REQ_UPDATE, 32'd5001);          // clears window
    queue_event(ppsm_pkg::REQ_PULSE,  32'h8000_0000);
    queue_event(ppsm_pkg::REQ_PULSE,  32'h8000_0010);
    queue_event(ppsm_pkg::REQ_UPDATE, 32'h8000_0011);     // clear, then pending folds in
    wait_drained();

    // Random phases: mostly a running clock with pulses and updates mixed,
    // small intervals for real speeds, tiny ones for zero means, long jumps
    // for timeouts, and some events at arbitrary times.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(ppsm_pkg::CFG_SPEED_CONST, 32'd36000000 + $urandom_range(0, 1000000));
          write_reg(ppsm_pkg::CFG_TIMEOUT,     32'd1000000);
          n_items = 110;
        end
        1: begin
          write_reg(ppsm_pkg::CFG_SPEED_CONST, $urandom);
          write_reg(ppsm_pkg::CFG_TIMEOUT,     $urandom_range(3000, 20000));
          n_items = 110;  // long result stall falls in this phase
        end
        2: begin
          write_reg(ppsm_pkg::CFG_SPEED_CONST, 32'hFFFF_FFFF);
          write_reg(ppsm_pkg::CFG_TIMEOUT,     32'hFFFF_FFFF);
          n_items = 90;
        end
        default: begin
          write_reg(ppsm_pkg::CFG_SPEED_CONST, $urandom_range(100000, 9999999));
          write_reg(ppsm_pkg::CFG_TIMEOUT,     32'd0);
          n_items = 90;
        end
      endcase
      quiet_mode = (p == 2);
      clock_now  = $urandom;
      for (int i = 0; i < n_items; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          queue_event(1'($urandom_range(0, 1)), $urandom);
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 70) step = $urandom_range(1, 4000);
          else if (roll < 85) step = $urandom_range(0, 3);
          else step = $urandom_range(0, 3000000);
          clock_now = clock_now + step;
          queue_event(($urandom_range(0, 99) < 50) ? ppsm_pkg::REQ_PULSE
                                                   : ppsm_pkg::REQ_UPDATE, clock_now);
        end
      end
      wait_drained();
    end
    quiet_mode = 1'b0;

    // Tail: give any stray result time to show up.
    repeat (200) @(posedge clk_i);
    if (speed_expected.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", speed_expected.size()));

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ppsm_pkg.sv
hw/rtl/ppsm_in_if.sv
hw/rtl/ppsm_out_if.sv
hw/rtl/ppsm_div.sv
hw/rtl/pulse_period_speed_meter.sv
dv/testbench.sv
